### hw/rtl/multi_waveform_table_generator_assert.svh
// assertion macros used by the top-level rtl file
`ifndef MULTI_WAVEFORM_TABLE_GENERATOR_ASSERT_SVH
`define MULTI_WAVEFORM_TABLE_GENERATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MWTG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MWTG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mwtg_pkg.sv
`default_nettype none

package mwtg_pkg;

    localparam int MAX_LENGTH_LOG2 = 12;
    localparam int MAX_CHANNELS    = 8;
    localparam int SINE_TABLE_BITS = 10;

    // field and register widths
    localparam int SAMPLE_W    = 16;
    localparam int CHAN_W      = 3;
    localparam int FRAME_W     = 12;
    localparam int MODE_W      = 3;
    localparam int AMP_W       = 15;
    localparam int LOG2_W      = 4;
    localparam int CNT_W       = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;

    // internal widths
    localparam int POS_W    = MAX_LENGTH_LOG2;
    localparam int PHASE_W  = SINE_TABLE_BITS + 2;
    localparam int QTR_SIZE = 1 << SINE_TABLE_BITS;
    localparam int ROM_AW   = SINE_TABLE_BITS + 1;
    localparam int ROM_DW   = 17;
    localparam int MULT_W   = 18;
    localparam int PROD_W   = AMP_W + 1 + MULT_W;
    localparam int SHIFT_W  = 4;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [MODE_W-1:0] {
        MODE_SINE,
        MODE_SAW_UP,
        MODE_SAW_DOWN,
        MODE_TRIANGLE,
        MODE_SQUARE
    } wave_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WAVE_MODE,
        CFG_AMPLITUDE,
        CFG_LENGTH_LOG2,
        CFG_CHANNEL_COUNT
    } cfg_index_t;

    typedef logic [ROM_DW-1:0] sine_rom_t [0:QTR_SIZE];

    // truncating unsigned division by shift and subtract, used only for the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // quarter-wave sine, alternating taylor series in unsigned q30
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] divisor;
        for (int k = 0; k <= QTR_SIZE; k++)
        begin
            x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
            term = x;
            sum  = x;
            for (int i = 1; i <= 7; i++)
            begin
                divisor = 64'((2 * i) * (2 * i + 1));
                term    = (term * x) >> 30;
                term    = udiv64((term * x) >> 30, divisor);
                if ((i & 1) == 1)
                    sum = (sum >= term) ? sum - term : 64'd0;
                else
                    sum = sum + term;
            end
            sum = (sum + 64'd16384) >> 15;
            if (sum > 64'd32768)
                sum = 64'd32768;
            rom[k] = ROM_DW'(sum);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

### hw/rtl/mwtg_ctrl_if.sv
`default_nettype none

interface mwtg_ctrl_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

### hw/rtl/mwtg_wave_if.sv
`default_nettype none

interface mwtg_wave_if;
    logic                                valid;
    logic                                ready;
    logic signed [mwtg_pkg::SAMPLE_W-1:0] sample;
    logic [mwtg_pkg::CHAN_W-1:0]          channel;
    logic [mwtg_pkg::FRAME_W-1:0]         frame_start;
    logic                                last;

    modport source (output valid, output sample, output channel, output frame_start,
                    output last, input ready);
    modport sink (input valid, input sample, input channel, input frame_start,
                  input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/mwtg_sine_rom.sv
`default_nettype none

module mwtg_sine_rom (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [mwtg_pkg::ROM_AW-1:0] addr,
    output logic      [mwtg_pkg::ROM_DW-1:0] data
);

    logic [mwtg_pkg::ROM_DW-1:0] data_reg;

    // registered read, held while the stage stalls
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= mwtg_pkg::SINE_ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### hw/rtl/multi_waveform_table_generator.sv
// multi-waveform wavetable generator: every ctrl transfer yields exactly one wave transfer
// holding the next slot of a one-cycle buffer of 2^length_log2 slots, as a signed q1.15
// sample scaled by amplitude (sine from a quarter-wave rom, rising and falling saw,
// triangle, square). all channel_count interleaved slots of a frame carry the value of
// the frame start index. restart=1 returns to slot zero before the slot is produced.
// one item is accepted per clock unless the stages stall; three register stages (sine rom
// read register, multiplier register, output register) carry each item from its ctrl
// transfer to its wave transfer, and the ctrl side keeps accepting while a result waits
// as long as an internal stage is empty.
// configuration writes are taken at any time but must only be made while idle.
`default_nettype none

`include "multi_waveform_table_generator_assert.svh"

module multi_waveform_table_generator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [mwtg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mwtg_pkg::CFG_DATA_W-1:0]   cfg_data,
    mwtg_ctrl_if.sink                              ctrl,
    mwtg_wave_if.source                            wave
);

    localparam int POS_W    = mwtg_pkg::POS_W;
    localparam int PHASE_W  = mwtg_pkg::PHASE_W;
    localparam int MULT_W   = mwtg_pkg::MULT_W;
    localparam int PROD_W   = mwtg_pkg::PROD_W;
    localparam int SHIFT_W  = mwtg_pkg::SHIFT_W;
    localparam int LOG2_W   = mwtg_pkg::LOG2_W;
    localparam int CNT_W    = mwtg_pkg::CNT_W;
    localparam int CHAN_W   = mwtg_pkg::CHAN_W;
    localparam int FRAME_W  = mwtg_pkg::FRAME_W;
    localparam int ROM_AW   = mwtg_pkg::ROM_AW;
    localparam int ROM_DW   = mwtg_pkg::ROM_DW;
    localparam int SAMPLE_W = mwtg_pkg::SAMPLE_W;

    // full-scale multiplicand, so that a * full / 2^15 gives a exactly
    localparam logic signed [MULT_W-1:0]  FULL_SCALE = MULT_W'(1 << (SAMPLE_W - 1));
    localparam logic [SHIFT_W-1:0]        Q15_SHIFT  = SHIFT_W'(SAMPLE_W - 1);
    localparam logic signed [PROD_W:0]    SAT_HI     = (PROD_W + 1)'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [PROD_W:0]    SAT_LO     = -((PROD_W + 1)'(1 << (SAMPLE_W - 1)));

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [mwtg_pkg::MODE_W-1:0] wave_mode_reg;
    logic [mwtg_pkg::AMP_W-1:0]  amplitude_reg;
    logic [LOG2_W-1:0]           length_log2_reg;
    logic [CNT_W-1:0]            channel_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg     <= mwtg_pkg::MODE_W'(0);
            amplitude_reg     <= mwtg_pkg::AMP_W'(16384);
            length_log2_reg   <= LOG2_W'(9);
            channel_count_reg <= CNT_W'(2);
        end
        else if (cfg_we)
        begin
            unique case (mwtg_pkg::cfg_index_t'(cfg_index))
                mwtg_pkg::CFG_WAVE_MODE:     wave_mode_reg     <= cfg_data[mwtg_pkg::MODE_W-1:0];
                mwtg_pkg::CFG_AMPLITUDE:     amplitude_reg     <= cfg_data[mwtg_pkg::AMP_W-1:0];
                mwtg_pkg::CFG_LENGTH_LOG2:   length_log2_reg   <= cfg_data[LOG2_W-1:0];
                mwtg_pkg::CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CNT_W-1:0];
                default:                     wave_mode_reg     <= wave_mode_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stage enables: each stage moves when the one after it has room
    // ---------------------------------------------------------------
    logic out_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_en;
    logic s2_en;
    logic s1_en;
    logic ctrl_xfer;

    assign out_en     = !out_valid_reg || wave.ready;
    assign s2_en      = !s2_valid_reg || out_en;
    assign s1_en      = !s1_valid_reg || s2_en;
    assign ctrl.ready = s1_en;
    assign ctrl_xfer  = ctrl.valid && s1_en;

    // ---------------------------------------------------------------
    // slot position state and front-end decode
    // ---------------------------------------------------------------
    logic [POS_W-1:0]  slot_pos_reg;
    logic [POS_W-1:0]  frame_base_reg;
    logic [CHAN_W-1:0] chan_pos_reg;
    logic [POS_W-1:0]  slot_pos_next;
    logic [POS_W-1:0]  frame_base_next;
    logic [CHAN_W-1:0] chan_pos_next;

    logic [POS_W-1:0]  slot_cur;
    logic [POS_W-1:0]  frame_cur;
    logic [CHAN_W-1:0] chan_cur;
    logic [LOG2_W-1:0] n_eff;
    logic [CNT_W-1:0]  nch;
    logic [POS_W:0]    len_w;
    logic [POS_W-1:0]  len_mask;
    logic [POS_W-1:0]  phase;
    logic [POS_W:0]    q4;
    logic [POS_W:0]    q4x3;
    logic              last_cur;
    logic [POS_W-1:0]  slot_inc;

    logic signed [MULT_W-1:0] len_s;
    logic signed [MULT_W-1:0] phase_s;
    logic signed [MULT_W-1:0] mult_other;
    logic [SHIFT_W-1:0]       shift_amt;
    logic                     is_sine;

    logic [POS_W+PHASE_W-1:0]          phase_ext;
    logic [PHASE_W-1:0]                 rom_phase;
    logic [1:0]                         quadrant;
    logic [mwtg_pkg::SINE_TABLE_BITS-1:0] rom_k;
    logic [ROM_AW-1:0]                  rom_addr;

    always_comb
    begin
        // restart zeroes the state before this slot is produced
        slot_cur  = ctrl.restart ? '0 : slot_pos_reg;
        frame_cur = ctrl.restart ? '0 : frame_base_reg;
        chan_cur  = ctrl.restart ? '0 : chan_pos_reg;

        // clamp length and channel count into their legal ranges
        if (length_log2_reg < LOG2_W'(2))
            n_eff = LOG2_W'(2);
        else if (length_log2_reg > LOG2_W'(mwtg_pkg::MAX_LENGTH_LOG2))
            n_eff = LOG2_W'(mwtg_pkg::MAX_LENGTH_LOG2);
        else
            n_eff = length_log2_reg;

        if (channel_count_reg == '0)
            nch = CNT_W'(1);
        else if (channel_count_reg > CNT_W'(mwtg_pkg::MAX_CHANNELS))
            nch = CNT_W'(mwtg_pkg::MAX_CHANNELS);
        else
            nch = channel_count_reg;

        len_w    = (POS_W + 1)'(32'd1 << n_eff);
        len_mask = POS_W'(len_w - (POS_W + 1)'(1));
        phase    = frame_cur & len_mask;
        q4       = len_w >> 2;
        q4x3     = q4 + (q4 << 1);
        last_cur = slot_cur >= len_mask;

        // advance to the next slot, wrapping to zero after the last; a new frame takes the new slot index
        slot_inc = slot_cur + POS_W'(1);
        if (last_cur)
        begin
            slot_pos_next   = '0;
            frame_base_next = '0;
            chan_pos_next   = '0;
        end
        else if (({1'b0, chan_cur} + CNT_W'(1)) >= nch)
        begin
            slot_pos_next   = slot_inc;
            frame_base_next = slot_inc;
            chan_pos_next   = '0;
        end
        else
        begin
            slot_pos_next   = slot_inc;
            frame_base_next = frame_cur;
            chan_pos_next   = chan_cur + CHAN_W'(1);
        end

        // multiplicand and rounding shift for the non-rom waveforms
        len_s     = MULT_W'(len_w);
        phase_s   = MULT_W'(phase);
        is_sine   = 1'b0;
        shift_amt = Q15_SHIFT;
        case (mwtg_pkg::wave_mode_t'(wave_mode_reg))
            mwtg_pkg::MODE_SINE:
            begin
                is_sine    = 1'b1;
                mult_other = '0;
            end
            mwtg_pkg::MODE_SAW_UP:
            begin
                mult_other = (phase_s <<< 1) - len_s;
                shift_amt  = SHIFT_W'(n_eff);
            end
            mwtg_pkg::MODE_SAW_DOWN:
            begin
                mult_other = len_s - (phase_s <<< 1);
                shift_amt  = SHIFT_W'(n_eff);
            end
            mwtg_pkg::MODE_TRIANGLE:
            begin
                if ({1'b0, phase} < q4)
                    mult_other = phase_s <<< 2;
                else if ({1'b0, phase} < q4x3)
                    mult_other = (len_s <<< 1) - (phase_s <<< 2);
                else
                    mult_other = (phase_s <<< 2) - (len_s <<< 2);
                shift_amt = SHIFT_W'(n_eff);
            end
            mwtg_pkg::MODE_SQUARE:
            begin
                mult_other = ({1'b0, phase} < (len_w >> 1)) ? FULL_SCALE : -FULL_SCALE;
            end
            default:
            begin
                // undefined modes give silence
                mult_other = '0;
            end
        endcase

        // sine table phase: scale the slot phase onto the rom's full-cycle index
        phase_ext = (POS_W + PHASE_W)'(phase);
        if (n_eff >= LOG2_W'(PHASE_W))
            rom_phase = PHASE_W'(phase_ext >> (n_eff - LOG2_W'(PHASE_W)));
        else
            rom_phase = PHASE_W'(phase_ext << (LOG2_W'(PHASE_W) - n_eff));
        quadrant = rom_phase[PHASE_W-1 -: 2];
        rom_k    = rom_phase[mwtg_pkg::SINE_TABLE_BITS-1:0];
        // odd quadrants read the table mirrored
        if (quadrant[0])
            rom_addr = ROM_AW'(mwtg_pkg::QTR_SIZE) - ROM_AW'(rom_k);
        else
            rom_addr = ROM_AW'(rom_k);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_pos_reg   <= '0;
            frame_base_reg <= '0;
            chan_pos_reg   <= '0;
        end
        else if (ctrl_xfer)
        begin
            slot_pos_reg   <= slot_pos_next;
            frame_base_reg <= frame_base_next;
            chan_pos_reg   <= chan_pos_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: decoded item plus sine rom read
    // ---------------------------------------------------------------
    logic [ROM_DW-1:0]        rom_data;
    logic signed [MULT_W-1:0] s1_mult_reg;
    logic [SHIFT_W-1:0]       s1_shift_reg;
    logic                     s1_sine_reg;
    logic                     s1_neg_reg;
    logic [CHAN_W-1:0]        s1_chan_reg;
    logic [FRAME_W-1:0]       s1_frame_reg;
    logic                     s1_last_reg;

    mwtg_sine_rom u_sine_rom (
        .clk  (clk),
        .en   (s1_en),
        .addr (rom_addr),
        .data (rom_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_mult_reg  <= mult_other;
            s1_shift_reg <= shift_amt;
            s1_sine_reg  <= is_sine;
            s1_neg_reg   <= quadrant[1];
            s1_chan_reg  <= chan_cur;
            s1_frame_reg <= FRAME_W'(frame_cur);
            s1_last_reg  <= last_cur;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: amplitude multiply
    // ---------------------------------------------------------------
    logic signed [MULT_W-1:0] mult_sel;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic [SHIFT_W-1:0]       s2_shift_reg;
    logic [CHAN_W-1:0]        s2_chan_reg;
    logic [FRAME_W-1:0]       s2_frame_reg;
    logic                     s2_last_reg;

    always_comb
    begin
        if (s1_sine_reg)
            mult_sel = s1_neg_reg ? -$signed(MULT_W'(rom_data)) : $signed(MULT_W'(rom_data));
        else
            mult_sel = s1_mult_reg;
        prod_next = $signed({1'b0, amplitude_reg}) * mult_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            s2_prod_reg  <= prod_next;
            s2_shift_reg <= s1_shift_reg;
            s2_chan_reg  <= s1_chan_reg;
            s2_frame_reg <= s1_frame_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // ---------------------------------------------------------------
    // output stage: round half up, shift, saturate to q1.15
    // ---------------------------------------------------------------
    logic signed [PROD_W:0]       round_sum;
    logic signed [PROD_W:0]       shifted;
    logic signed [SAMPLE_W-1:0]   sample_next;
    logic signed [SAMPLE_W-1:0]   sample_reg;
    logic [CHAN_W-1:0]            chan_reg;
    logic [FRAME_W-1:0]           frame_reg;
    logic                         last_reg;

    always_comb
    begin
        round_sum = {s2_prod_reg[PROD_W-1], s2_prod_reg}
                  + ((PROD_W + 1)'(1) << (s2_shift_reg - SHIFT_W'(1)));
        shifted   = round_sum >>> s2_shift_reg;
        if (shifted > SAT_HI)
            sample_next = SAT_HI[SAMPLE_W-1:0];
        else if (shifted < SAT_LO)
            sample_next = SAT_LO[SAMPLE_W-1:0];
        else
            sample_next = shifted[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            sample_reg <= sample_next;
            chan_reg   <= s2_chan_reg;
            frame_reg  <= s2_frame_reg;
            last_reg   <= s2_last_reg;
        end
    end

    assign wave.valid       = out_valid_reg;
    assign wave.sample      = sample_reg;
    assign wave.channel     = chan_reg;
    assign wave.frame_start = frame_reg;
    assign wave.last        = last_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // the final slot of a buffer always wraps all position state to zero
    `MWTG_ASSERT_NEXT(a_wrap_after_last, clk, rst_n, ctrl_xfer && last_cur,
        slot_pos_reg == '0 && frame_base_reg == '0 && chan_pos_reg == '0,
        "position state did not wrap after the last slot")
    // an accepted item always lands in stage 1
    `MWTG_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, ctrl_xfer, s1_valid_reg,
        "accepted item missing from stage 1")
    // a stalled stage 1 keeps its rom data
    `MWTG_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s2_en,
        s1_valid_reg && $stable(rom_data) && $stable(s1_mult_reg),
        "stage 1 changed while stalled")
    // a stalled stage 2 keeps its product
    `MWTG_ASSERT_NEXT(a_s2_hold, clk, rst_n, s2_valid_reg && !out_en,
        s2_valid_reg && $stable(s2_prod_reg),
        "stage 2 changed while stalled")
    // the input side is never blocked while stage 1 is empty
    `MWTG_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !s1_valid_reg, ctrl.ready,
        "input not ready with stage 1 empty")

endmodule

`default_nettype wire

### test/mwtg_slot_checker.sv
`timescale 1ns / 100ps

module mwtg_slot_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [mwtg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mwtg_pkg::CFG_DATA_W-1:0]  cfg_data,
    mwtg_ctrl_if                                  ctrl,
    mwtg_wave_if                                  wave,
    output int                                    mismatch_count,
    output int                                    outstanding
);
    import mwtg_pkg::*;

    localparam int QUARTER      = 1 << SINE_TABLE_BITS;
    localparam int PHASE_BITS   = SINE_TABLE_BITS + 2;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]          channel;
        logic [FRAME_W-1:0]         frame_start;
        logic                       last;
    } slot_t;

    logic [16:0]       quarter_sine [0:QUARTER];
    slot_t             slots_due [$];
    slot_t             want;
    slot_t             got;

    logic [MODE_W-1:0] mode_reg;
    logic [AMP_W-1:0]  amp_reg;
    logic [LOG2_W-1:0] log2_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [POS_W-1:0]  slot_pos;
    logic [POS_W-1:0]  frame_base;
    logic [CHAN_W-1:0] chan_pos;

    // quarter-wave table, taylor series in unsigned q30 with truncated products
    initial
    begin : sine_fill
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        for (int k = 0; k <= QUARTER; k++)
        begin
            x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
            term = x;
            sum  = x;
            for (int i = 1; i <= 7; i++)
            begin
                term = (term * x) >> 30;
                term = ((term * x) >> 30) / 64'((2 * i) * (2 * i + 1));
                if (i % 2 == 1)
                    sum = (sum >= term) ? sum - term : 0;
                else
                    sum = sum + term;
            end
            sum = (sum + 64'd16384) >> 15;
            if (sum > 64'd32768)
                sum = 64'd32768;
            quarter_sine[k] = 17'(sum);
        end
    end

    // floor((v + 2^(sh-1)) / 2^sh)
    function automatic longint round_shift(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint sine_sample(input longint a, input int unsigned p,
                                           input int unsigned lg);
        int unsigned f;
        int unsigned quad;
        int unsigned k;
        longint      s;
        if (lg >= PHASE_BITS)
            f = p >> (lg - PHASE_BITS);
        else
            f = p << (PHASE_BITS - lg);
        quad = (f >> SINE_TABLE_BITS) & 3;
        k    = f & (QUARTER - 1);
        if (quad == 0 || quad == 2)
            s = longint'(quarter_sine[k]);
        else
            s = longint'(quarter_sine[QUARTER - k]);
        if (quad >= 2)
            s = -s;
        return round_shift(a * s, 15);
    endfunction

    // next slot of the buffer, advancing slot, frame and channel position
    function automatic slot_t predict_slot(input logic restart);
        int unsigned lg;
        int unsigned len;
        int unsigned nch;
        int unsigned p;
        int unsigned q4;
        longint      a;
        longint      t;
        longint      v;
        slot_t       r;
        if (restart)
        begin
            slot_pos   = '0;
            frame_base = '0;
            chan_pos   = '0;
        end
        lg  = log2_reg;
        if (lg < 2)
            lg = 2;
        if (lg > MAX_LENGTH_LOG2)
            lg = MAX_LENGTH_LOG2;
        len = 1 << lg;
        nch = count_reg;
        if (nch < 1)
            nch = 1;
        if (nch > MAX_CHANNELS)
            nch = MAX_CHANNELS;
        p  = frame_base & (len - 1);
        a  = longint'(amp_reg);
        q4 = len >> 2;

        case (wave_mode_t'(mode_reg))
            MODE_SINE:     v = sine_sample(a, p, lg);
            MODE_SAW_UP:   v = round_shift(a * (2 * longint'(p) - longint'(len)), lg);
            MODE_SAW_DOWN: v = round_shift(a * (longint'(len) - 2 * longint'(p)), lg);
            MODE_TRIANGLE:
            begin
                if (p < q4)
                    t = 4 * longint'(p);
                else if (p < 3 * q4)
                    t = 2 * longint'(len) - 4 * longint'(p);
                else
                    t = 4 * longint'(p) - 4 * longint'(len);
                v = round_shift(a * t, lg);
            end
            MODE_SQUARE:   v = (p < (len >> 1)) ? a : -a;
            default:       v = 0;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;

        r.sample      = v[SAMPLE_W-1:0];
        r.channel     = chan_pos;
        r.frame_start = frame_base;
        r.last        = (slot_pos >= len - 1);

        if (r.last)
        begin
            slot_pos   = '0;
            frame_base = '0;
            chan_pos   = '0;
        end
        else
        begin
            slot_pos = slot_pos + 1'b1;
            if (int'(chan_pos) + 1 >= nch)
            begin
                chan_pos   = '0;
                frame_base = slot_pos;
            end
            else
                chan_pos = chan_pos + 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       = MODE_SINE;
            amp_reg        = 15'd16384;
            log2_reg       = 4'd9;
            count_reg      = 4'd2;
            slot_pos       = '0;
            frame_base     = '0;
            chan_pos       = '0;
            slots_due.delete();
            mismatch_count = 0;
            outstanding    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_WAVE_MODE:     mode_reg  = cfg_data[MODE_W-1:0];
                    CFG_AMPLITUDE:     amp_reg   = cfg_data[AMP_W-1:0];
                    CFG_LENGTH_LOG2:   log2_reg  = cfg_data[LOG2_W-1:0];
                    CFG_CHANNEL_COUNT: count_reg = cfg_data[CNT_W-1:0];
                    default:           ;
                endcase
            end

            if (wave.valid && wave.ready)
            begin
                got.sample      = wave.sample;
                got.channel     = wave.channel;
                got.frame_start = wave.frame_start;
                got.last        = wave.last;
                if (slots_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected slot: sample %0d channel %0d frame %0d last %0d",
                                 $time, got.sample, got.channel, got.frame_start, got.last);
                end
                else
                begin
                    want = slots_due.pop_front();
                    if (got.sample !== want.sample || got.channel !== want.channel ||
                        got.frame_start !== want.frame_start || got.last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"%0t: slot mismatch: expected sample %0d channel %0d ",
                                      "frame %0d last %0d, got sample %0d channel %0d ",
                                      "frame %0d last %0d"},
                                     $time, want.sample, want.channel, want.frame_start,
                                     want.last, got.sample, got.channel, got.frame_start,
                                     got.last);
                    end
                end
            end

            if (ctrl.valid && ctrl.ready)
                slots_due.push_back(predict_slot(ctrl.restart));

            outstanding = slots_due.size();
        end
    end

endmodule

### test/multi_waveform_table_generator_tb.sv
`timescale 1ns / 100ps

module multi_waveform_table_generator_tb;
    import mwtg_pkg::*;

    localparam int TOTAL_ITEMS      = 1700;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 4;     // covers the three-stage pipe
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int AMP_MAX          = (1 << AMP_W) - 1;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    mwtg_ctrl_if ctrl_ch ();
    mwtg_wave_if wave_ch ();

    int mismatch_count;
    int outstanding;
    int items_sent    = 0;
    int quiet_cycles  = 0;
    bit idle_on       = 1'b1;   // shared by both sides, redrawn per phase
    bit long_hold_req = 1'b0;   // sender asks the wave side for one long hold-off

    multi_waveform_table_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl_ch),
        .wave      (wave_ch)
    );

    // watches both channels and the register port, predicts every slot
    mwtg_slot_checker slot_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .ctrl           (ctrl_ch),
        .wave           (wave_ch),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #6 clk = ~clk;

    // watchdog: any transfer or register write counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (ctrl_ch.valid && ctrl_ch.ready) ||
            (wave_ch.valid && wave_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // register write: a one-cycle write enable pulse, then the enable drops
    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_all(input int unsigned mode, input int unsigned amp,
                           input int unsigned lg, input int unsigned cnt);
        write_reg(CFG_WAVE_MODE, mode);
        write_reg(CFG_AMPLITUDE, amp);
        write_reg(CFG_LENGTH_LOG2, lg);
        write_reg(CFG_CHANNEL_COUNT, cnt);
    endtask

    // offer count slot requests, each after a random gap while idle_on is set; restart may be
    // scattered through the batch to cut buffers short
    task automatic send_slots(input int count, input bit first_restart,
                              input bit scatter_restart);
        int gap;
        for (int n = 0; n < count; n++)
        begin
            gap = idle_on ? $urandom_range(0, 15) : 0;
            if (gap > 0)
            begin
                ctrl_ch.valid   <= 1'b0;
                // restart toggles while idle, must be ignored
                ctrl_ch.restart <= 1'($urandom_range(0, 1));
                repeat (gap) @(negedge clk);
            end
            ctrl_ch.valid <= 1'b1;
            if (n == 0)
                ctrl_ch.restart <= first_restart;
            else
                ctrl_ch.restart <= scatter_restart && ($urandom_range(0, 23) == 0);
            do
                @(posedge clk);
            while (!(ctrl_ch.valid && ctrl_ch.ready));
            @(negedge clk);
            items_sent++;
        end
    endtask

    // stop offering and wait until every predicted slot has come out
    task automatic drain;
        ctrl_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // new random settings; most lengths small so buffers wrap often,
    // now and then the clamped extremes and undefined modes
    task automatic randomize_settings(input bit write_all);
        if (write_all || $urandom_range(0, 1))
        begin
            if ($urandom_range(0, 9) < 8)
                write_reg(CFG_WAVE_MODE, $urandom_range(int'(MODE_SINE), int'(MODE_SQUARE)));
            else
                write_reg(CFG_WAVE_MODE, $urandom_range(int'(MODE_SQUARE) + 1,
                                                        (1 << MODE_W) - 1));
        end
        if (write_all || $urandom_range(0, 1))
        begin
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_AMPLITUDE, 0);
                1:       write_reg(CFG_AMPLITUDE, AMP_MAX);
                default: write_reg(CFG_AMPLITUDE, $urandom_range(0, AMP_MAX));
            endcase
        end
        if (write_all || $urandom_range(0, 1))
        begin
            if ($urandom_range(0, 9) < 7)
                write_reg(CFG_LENGTH_LOG2, $urandom_range(2, 7));
            else
                write_reg(CFG_LENGTH_LOG2, $urandom_range(0, (1 << LOG2_W) - 1));
        end
        if (write_all || $urandom_range(0, 1))
            write_reg(CFG_CHANNEL_COUNT, $urandom_range(0, (1 << CNT_W) - 1));
    endtask

    // wave side: random stall per slot, one long hold-off on request
    initial
    begin : wave_sink
        int gap;
        wave_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                wave_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            gap = idle_on ? $urandom_range(0, 15) : 0;
            if (gap > 0)
            begin
                wave_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            wave_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(wave_ch.valid && wave_ch.ready));
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int phase;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_WAVE_MODE;
        cfg_data        = '0;
        ctrl_ch.valid   = 1'b0;
        ctrl_ch.restart = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset settings first, no restart, so the reset state is seen
        send_slots(2, 1'b0, 1'b0);
        drain;

        // every mode at full amplitude over a four-slot buffer, one channel,
        // so each quadrant and each triangle and square segment is hit
        set_all(MODE_SINE, AMP_MAX, 2, 1);
        send_slots(4, 1'b1, 1'b0);
        drain;
        write_reg(CFG_WAVE_MODE, MODE_SAW_UP);
        send_slots(2, 1'b0, 1'b0);
        drain;
        write_reg(CFG_WAVE_MODE, MODE_SAW_DOWN);
        send_slots(2, 1'b0, 1'b0);
        drain;
        write_reg(CFG_WAVE_MODE, MODE_TRIANGLE);
        send_slots(4, 1'b0, 1'b0);
        drain;
        write_reg(CFG_WAVE_MODE, MODE_SQUARE);
        send_slots(4, 1'b0, 1'b0);
        drain;

        // undefined modes give a zero sample
        for (int m = int'(MODE_SQUARE) + 1; m < (1 << MODE_W); m++)
        begin
            write_reg(CFG_WAVE_MODE, m);
            send_slots(1, 1'b0, 1'b0);
            drain;
        end

        // length above range clamps to the maximum, channel count zero acts as one,
        // zero amplitude
        set_all(MODE_SQUARE, 0, (1 << LOG2_W) - 1, 0);
        send_slots(3, 1'b1, 1'b0);
        drain;

        // shrink the buffer mid-way: slot three is already the last slot of a
        // clamped four-slot buffer; three channels leave a short last frame
        set_all(MODE_TRIANGLE, AMP_MAX, 0, 3);
        send_slots(5, 1'b0, 1'b0);
        drain;

        // random phases until the item budget is used up
        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            randomize_settings(phase == 0);
            idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 2)
            begin
                // sender keeps offering while the wave side holds off,
                // so the pipe fills and ctrl ready drops
                idle_on       = 1'b0;
                long_hold_req = 1'b1;
                send_slots(90, 1'b1, 1'b1);
            end
            else
                send_slots($urandom_range(10, 90), 1'($urandom_range(0, 1)), 1'b1);
            drain;
            phase++;
        end

        // anything the block emits from here on shows up as an unexpected slot
        repeat (SETTLE_CYCLES * 4) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
